>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the following edge.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bst_pkg.sv
// Shared types, constants and character helpers for the byte stream tokenizer.
package bst_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF = 8;
	localparam int OUTQ_DEPTH      = 4;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [4:0] {
		KIND_EOF        = 5'd0,
		KIND_ASSIGN     = 5'd1,
		KIND_EQUALS     = 5'd2,
		KIND_SEMICOLON  = 5'd3,
		KIND_LPAREN     = 5'd4,
		KIND_RPAREN     = 5'd5,
		KIND_COMMA      = 5'd6,
		KIND_PLUS       = 5'd7,
		KIND_MINUS      = 5'd8,
		KIND_BANG       = 5'd9,
		KIND_NOT_EQUALS = 5'd10,
		KIND_SLASH      = 5'd11,
		KIND_STAR       = 5'd12,
		KIND_LESS       = 5'd13,
		KIND_GREATER    = 5'd14,
		KIND_LBRACE     = 5'd15,
		KIND_RBRACE     = 5'd16,
		KIND_IDENT      = 5'd17,
		KIND_INTEGER    = 5'd18,
		KIND_ILLEGAL    = 5'd19
	} kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_IDENT  = 4'b0010,
		MODE_NUMBER = 4'b0100,
		MODE_HELD   = 4'b1000
	} mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [15:0] start;
		logic [7:0]  length;
		logic [7:0]  first;
		logic        last;
	} token_t;

	// Tokens handed from the scanner to the output queue in the same cycle.
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic kind_t single_kind(logic [7:0] c);
		kind_t k;
		case (c)
			8'h3B:   k = KIND_SEMICOLON; // ;
			8'h28:   k = KIND_LPAREN;    // (
			8'h29:   k = KIND_RPAREN;    // )
			8'h2C:   k = KIND_COMMA;     // ,
			8'h2B:   k = KIND_PLUS;      // +
			8'h2D:   k = KIND_MINUS;     // -
			8'h2F:   k = KIND_SLASH;     // /
			8'h2A:   k = KIND_STAR;      // *
			8'h3C:   k = KIND_LESS;      // <
			8'h3E:   k = KIND_GREATER;   // >
			8'h7B:   k = KIND_LBRACE;    // {
			8'h7D:   k = KIND_RBRACE;    // }
			default: k = KIND_ILLEGAL;
		endcase
		return k;
	endfunction

	// Lengths wider than the output field are clipped to its maximum.
	function automatic token_t make_token(kind_t k, logic [15:0] start, logic [15:0] len,
			logic [7:0] first);
		token_t t;
		t.kind   = k;
		t.start  = start;
		t.length = (len > 16'd255) ? 8'hFF : len[7:0];
		t.first  = first;
		t.last   = 1'b1;
		return t;
	endfunction

endpackage

>>> hdl/bst_scan.sv
// Input byte register, scan state and the token logic for one byte.
module bst_scan import bst_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] byte_in,
	input  logic       room,
	output push_t      push
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	logic [7:0]             byte_s1;
	logic                   valid_s1;
	logic                   accept;
	logic                   advance;

	mode_t                  mode_q, mode_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, off_inc;
	logic [7:0]             held_q, held_d;

	logic                   flush_v, new_v, general;
	token_t                 flush_t, new_t;
	push_t                  push_c;

	function automatic logic [15:0] off16(logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_in;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		len_d   = len_q;
		off_d   = off_q;
		held_d  = held_q;
		flush_v = 1'b0;
		new_v   = 1'b0;
		flush_t = '0;
		new_t   = '0;
		general = 1'b1;
		off_inc = off_q + 1'b1;

		unique case (mode_q)
			MODE_IDENT, MODE_NUMBER: begin
				if ((mode_q == MODE_IDENT) ? is_letter(byte_s1) : is_digit(byte_s1)) begin
					general = 1'b0;
					if (len_q != LEN_MAX) begin
						len_d = len_q + 1'b1;
					end
					off_d = off_inc;
				end else begin
					flush_v = 1'b1;
					flush_t = make_token((mode_q == MODE_IDENT) ? KIND_IDENT : KIND_INTEGER,
						off16(start_q), 16'(len_q), held_q);
					mode_d  = MODE_IDLE;
				end
			end
			MODE_HELD: begin
				mode_d = MODE_IDLE;
				if (byte_s1 == CH_EQ) begin
					general = 1'b0;
					new_v   = 1'b1;
					new_t   = make_token((held_q == CH_BANG) ? KIND_NOT_EQUALS : KIND_EQUALS,
						off16(start_q), 16'd2, held_q);
					off_d   = off_inc;
				end else begin
					flush_v = 1'b1;
					flush_t = make_token((held_q == CH_BANG) ? KIND_BANG : KIND_ASSIGN,
						off16(start_q), 16'd1, held_q);
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		if (general) begin
			if (byte_s1 == CH_NUL) begin
				// End of stream: emit eof and return every scan state register to its reset value.
				new_v   = 1'b1;
				new_t   = make_token(KIND_EOF, off16(off_q), 16'd1, CH_NUL);
				mode_d  = MODE_IDLE;
				start_d = '0;
				len_d   = '0;
				off_d   = '0;
				held_d  = '0;
			end else if (is_space(byte_s1)) begin
				off_d = off_inc;
			end else if (byte_s1 == CH_EQ || byte_s1 == CH_BANG ||
					is_letter(byte_s1) || is_digit(byte_s1)) begin
				if (is_letter(byte_s1)) begin
					mode_d = MODE_IDENT;
				end else if (is_digit(byte_s1)) begin
					mode_d = MODE_NUMBER;
				end else begin
					mode_d = MODE_HELD;
				end
				start_d = off_q;
				len_d   = LENGTH_BITS'(1);
				held_d  = byte_s1;
				off_d   = off_inc;
			end else begin
				new_v = 1'b1;
				new_t = make_token(single_kind(byte_s1), off16(off_q), 16'd1, byte_s1);
				off_d = off_inc;
			end
		end

		push_c.cnt       = advance ? (2'(flush_v) + 2'(new_v)) : 2'd0;
		push_c.tok0      = flush_v ? flush_t : new_t;
		push_c.tok0.last = !(flush_v && new_v);
		push_c.tok1      = new_t;
		push_c.tok1.last = 1'b1;
	end

	assign push = push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			off_q   <= '0;
			held_q  <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			len_q   <= len_d;
			off_q   <= off_d;
			held_q  <= held_d;
		end
	end

endmodule

>>> hdl/bst_outq.sv
// Small output queue that takes up to two tokens a cycle and gives one.
module bst_outq import bst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	output logic        token_valid,
	input  logic        token_stall,
	output token_t      head
);

	localparam int PTR_BITS = $clog2(OUTQ_DEPTH);
	localparam int CNT_BITS = PTR_BITS + 1;

	token_t              mem [OUTQ_DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign token_valid = (count_q != '0);
	assign pop         = token_valid && !token_stall;
	// Room for two words, so a byte that closes a run can always be taken.
	assign room        = (count_q <= CNT_BITS'(OUTQ_DEPTH - 2));
	assign head        = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + 1'b1] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_BITS'(push.cnt);
			rd_q    <= rd_q + PTR_BITS'(pop);
			count_q <= count_q + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
		end
	end

endmodule

>>> hdl/byte_stream_tokenizer.sv
// Byte stream tokenizer: takes one source byte a word and gives tokens as they close.
// A byte is taken in every cycle while the output keeps up: it is registered, scanned from
// that register and its tokens are written to the output queue. A byte may give two tokens
// (a closed run or a held '=' or '!', then a token of its own), and the output queue of four
// words drains one token a cycle unless token_stall is high, so the input stalls while the
// scan stage holds a byte and fewer than two queue entries are free. Byte 0 flushes any open
// token, gives eof and sets the offset back to zero.
module byte_stream_tokenizer import bst_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_in,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [4:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [7:0]  token_length,
	output logic [7:0]  first_byte,
	output logic        last_of_run
);

	push_t  push;
	logic   room;
	token_t head;

	bst_scan #(
		.OFFSET_BITS (OFFSET_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_in    (byte_in),
		.room       (room),
		.push       (push)
	);

	bst_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.head        (head)
	);

	assign token_kind   = head.kind;
	assign start_offset = head.start;
	assign token_length = head.length;
	assign first_byte   = head.first;
	assign last_of_run  = head.last;

endmodule

>>> hdl/bst_chk.sv
// Port-level checker for the byte stream tokenizer, bound to the top level.
`include "assert_macros.svh"

module bst_chk import bst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_stall,
	input logic        token_valid,
	input logic        token_stall,
	input logic [4:0]  token_kind,
	input logic [15:0] start_offset,
	input logic [7:0]  token_length,
	input logic [7:0]  first_byte,
	input logic        last_of_run
);

	// A stalled word keeps its contents.
	`CHK_NEXT(a_hold, clk, arst_n, token_valid && token_stall, token_valid && $stable(token_kind) && $stable(start_offset) && $stable(token_length) && $stable(first_byte) && $stable(last_of_run), "token word changed while stalled")

	// The input is held off only while tokens are waiting at the output.
	`CHK_ALWAYS(a_stall, clk, arst_n, !byte_stall || token_valid, "input stalled with no token waiting")

	// Eof always ends the tokens of its byte, with length one and a zero first byte.
	`CHK_ALWAYS(a_eof, clk, arst_n, !(token_valid && token_kind == KIND_EOF) || (token_length == 8'd1 && first_byte == CH_NUL && last_of_run), "malformed eof token")

	// Pair operators span two bytes and start with the held character.
	`CHK_ALWAYS(a_pair, clk, arst_n, !(token_valid && (token_kind == KIND_EQUALS || token_kind == KIND_NOT_EQUALS)) || (token_length == 8'd2 && last_of_run && (first_byte == CH_EQ || first_byte == CH_BANG)), "malformed pair operator")

	// Identifier and integer runs are never empty and start with a matching character.
	`CHK_ALWAYS(a_run, clk, arst_n, !(token_valid && (token_kind == KIND_IDENT || token_kind == KIND_INTEGER)) || (token_length != 8'd0 && (token_kind == KIND_IDENT ? is_letter(first_byte) : is_digit(first_byte))), "malformed run token")

endmodule

bind byte_stream_tokenizer bst_chk u_bst_chk (.*);
